// ===== rtl/gtg_pkg.sv =====
// Shared constants, register and opcode codes, and the arctangent table
// for the go-to-goal steering controller. Depends on nothing.
package gtg_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_POS_WIDTH    = 32;

    // Angle accumulator width, Q16 radians; holds pi plus the full atan sum.
    localparam int ZW = 20;
    // Width of the serial multiplier's second operand.
    localparam int MUL_BITS = 16;
    // Operand width of the small signed multiplier.
    localparam int MW = 20;
    localparam int ADDR_W = 5;

    localparam logic signed [ZW-1:0] PI_Q16     = ZW'(205887);
    localparam logic signed [18:0]   PI_Q13     = 19'sd25736;
    localparam logic signed [18:0]   TWO_PI_Q13 = 19'sd51472;
    localparam logic [MUL_BITS-1:0]  CORDIC_GAIN_Q16 = 16'd39797;

    localparam logic [1:0] OP_GOAL = 2'd0;
    localparam logic [1:0] OP_ODOM = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] ST_DRIVING   = 2'd0;
    localparam logic [1:0] ST_SUCCEEDED = 2'd1;
    localparam logic [1:0] ST_FAILED    = 2'd2;

    localparam logic [2:0] REG_GOAL_TOL    = 3'd0;
    localparam logic [2:0] REG_HEAD_TOL    = 3'd1;
    localparam logic [2:0] REG_MAX_LIN     = 3'd2;
    localparam logic [2:0] REG_MAX_ANG     = 3'd3;
    localparam logic [2:0] REG_LIN_GAIN    = 3'd4;
    localparam logic [2:0] REG_ANG_GAIN    = 3'd5;
    localparam logic [2:0] REG_ODOM_TMO    = 3'd6;

    localparam logic [30:0] RST_GOAL_TOL = 31'd9830;
    localparam logic [14:0] RST_HEAD_TOL = 15'd1638;
    localparam logic [14:0] RST_MAX_LIN  = 15'd2048;
    localparam logic [14:0] RST_MAX_ANG  = 15'd4915;
    localparam logic [15:0] RST_LIN_GAIN = 16'd205;
    localparam logic [15:0] RST_ANG_GAIN = 16'd384;
    localparam logic [15:0] RST_ODOM_TMO = 16'd15;

    // atan(2^-i) in Q16 radians, rounded.
    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = ZW'(51472);
            5'd1:    v = ZW'(30386);
            5'd2:    v = ZW'(16055);
            5'd3:    v = ZW'(8150);
            5'd4:    v = ZW'(4091);
            5'd5:    v = ZW'(2047);
            5'd6:    v = ZW'(1024);
            5'd7:    v = ZW'(512);
            5'd8:    v = ZW'(256);
            5'd9:    v = ZW'(128);
            5'd10:   v = ZW'(64);
            5'd11:   v = ZW'(32);
            5'd12:   v = ZW'(16);
            5'd13:   v = ZW'(8);
            5'd14:   v = ZW'(4);
            5'd15:   v = ZW'(2);
            5'd16:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/gtg_cordic.sv =====
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
// Depends on gtg_pkg for the arctangent table and pi.
module gtg_cordic #(
    parameter int CW    = 37,
    parameter int STEPS = gtg_pkg::DEF_CORDIC_STEPS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [CW-1:0]            i_x,
    input  logic signed [CW-1:0]            i_y,
    output logic                            o_done,
    output logic signed [CW-1:0]            o_x,
    output logic signed [gtg_pkg::ZW-1:0]   o_z
);
    localparam int IW = $clog2(STEPS);

    logic signed [CW-1:0]          r_x, r_y;
    logic signed [gtg_pkg::ZW-1:0] r_z;
    logic [IW-1:0]                 r_i;
    logic                          r_busy, r_done;
    logic signed [CW-1:0]          xs, ys;
    logic signed [gtg_pkg::ZW-1:0] at;

    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign at = gtg_pkg::atan_q16(5'(r_i));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (i_x == '0 && i_y == '0) begin
                    // A zero vector has no angle; report zero for both.
                    r_x    <= '0;
                    r_y    <= '0;
                    r_z    <= '0;
                    r_done <= 1'b1;
                end else if (i_x < 0) begin
                    r_x    <= -i_x;
                    r_y    <= -i_y;
                    r_z    <= (i_y >= 0) ? gtg_pkg::PI_Q16 : -gtg_pkg::PI_Q16;
                    r_busy <= 1'b1;
                end else begin
                    r_x    <= i_x;
                    r_y    <= i_y;
                    r_z    <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_y >= 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == IW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_z    = r_z;

endmodule

// ===== rtl/gtg_smul.sv =====
// Serial shift-add multiplier, one bit of the narrow operand per cycle.
// Depends on gtg_pkg for the narrow operand width.
module gtg_smul #(
    parameter int AW = 37
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [AW-1:0]                        i_a,
    input  logic [gtg_pkg::MUL_BITS-1:0]         i_b,
    output logic                                 o_done,
    output logic [AW+gtg_pkg::MUL_BITS-1:0]      o_p
);
    localparam int BW = gtg_pkg::MUL_BITS;
    localparam int PW = AW + BW;
    localparam int CNW = $clog2(BW);

    logic [PW-1:0]  r_a, r_p;
    logic [BW-1:0]  r_b;
    logic [CNW-1:0] r_cnt;
    logic           r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= PW'(i_a);
                r_b    <= i_b;
                r_p    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_p <= r_p + r_a;
                end
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

// ===== rtl/go_to_goal_steering_controller.sv =====
// Top level of the go-to-goal steering controller: APB register file,
// sequencer, small multiplier. Uses gtg_pkg, gtg_cordic and gtg_smul.
//
// The block takes one input beat at a time and is not ready while it works
// on it. A goal beat only stores the goal. An odometry beat runs the four
// quaternion products through a single multiplier in states S_Q0 to S_Q4,
// with the last one starting the CORDIC unit, then a vectoring pass of one
// micro-rotation per cycle, and then takes the yaw. A control tick that
// finds no goal or no odometry gives no result; a stale tick reports
// failure. Any other tick runs the vectoring pass, then the serial
// multiplier that scales the CORDIC magnitude, and then the arrival check;
// an arrival ends there, and a turn-in-place command after the heading
// term. When the heading is good enough to drive forward, the speed term
// uses the same serial multiplier once more. The result beat sits in an
// output register; the next input beat is taken while it waits, and a
// later result waits only until that register frees, which adds the
// stall cycles of the receiver to that tick.
module go_to_goal_steering_controller #(
    parameter int CORDIC_STEPS = gtg_pkg::DEF_CORDIC_STEPS,
    parameter int POS_WIDTH    = gtg_pkg::DEF_POS_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input item channel.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_operation,
    input  logic signed [31:0]           i_x_coord,
    input  logic signed [31:0]           i_y_coord,
    input  logic signed [15:0]           i_quat_x,
    input  logic signed [15:0]           i_quat_y,
    input  logic signed [15:0]           i_quat_z,
    input  logic signed [15:0]           i_quat_w,
    // Command channel.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [14:0]                  o_linear_speed,
    output logic signed [15:0]           o_angular_speed,
    output logic [1:0]                   o_status,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gtg_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    // Datapath width for the CORDIC: the position difference or the yaw
    // vector, plus headroom for the CORDIC gain and a sign.
    localparam int BASE_W = (POS_WIDTH + 1 > 34) ? POS_WIDTH + 1 : 34;
    localparam int CW = BASE_W + 3;
    localparam int PW = CW + gtg_pkg::MUL_BITS;
    localparam int MW = gtg_pkg::MW;
    localparam int ZW = gtg_pkg::ZW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_Q0     = 4'd1;
    localparam logic [3:0] S_Q1     = 4'd2;
    localparam logic [3:0] S_Q2     = 4'd3;
    localparam logic [3:0] S_Q3     = 4'd4;
    localparam logic [3:0] S_Q4     = 4'd5;
    localparam logic [3:0] S_YAW    = 4'd6;
    localparam logic [3:0] S_CORD   = 4'd7;
    localparam logic [3:0] S_MAG    = 4'd8;
    localparam logic [3:0] S_ARRIVE = 4'd9;
    localparam logic [3:0] S_ANG0   = 4'd10;
    localparam logic [3:0] S_ANG1   = 4'd11;
    localparam logic [3:0] S_LIN    = 4'd12;
    localparam logic [3:0] S_EMIT   = 4'd13;

    // Configuration registers.
    logic [30:0] r_goal_tol;
    logic [14:0] r_head_tol, r_max_lin, r_max_ang;
    logic [15:0] r_lin_gain, r_ang_gain, r_odom_tmo;

    // Controller state.
    logic [3:0]                  r_state;
    logic signed [POS_WIDTH-1:0] r_goal_x, r_goal_y, r_robot_x, r_robot_y;
    logic signed [15:0]          r_yaw;
    logic                        r_goal_valid, r_odom_valid;
    logic [15:0]                 r_age;

    // Working registers.
    logic signed [15:0]     r_qx, r_qy, r_qz, r_qw;
    logic signed [2*MW-1:0] r_prod;
    logic signed [CW-1:0]   r_acc1, r_acc2;
    logic [CW-1:0]          r_dist;
    logic signed [18:0]     r_err;
    logic [14:0]            r_res_lin;
    logic signed [15:0]     r_res_ang;
    logic [1:0]             r_res_status;

    // Output register.
    logic               r_out_valid;
    logic [14:0]        r_out_lin;
    logic signed [15:0] r_out_ang;
    logic [1:0]         r_out_status;

    logic in_fire, cfg_wr;
    logic [2:0] cfg_idx;
    logic [15:0] age_inc;

    logic signed [MW-1:0]     mul_a, mul_b;
    logic signed [CW-1:0]     prod_cw;
    logic                     cord_start, cord_done;
    logic signed [CW-1:0]     cord_x_in, cord_y_in, cord_x;
    logic signed [ZW-1:0]     cord_z;
    logic                     smul_start, smul_done;
    logic [CW-1:0]            smul_a;
    logic [gtg_pkg::MUL_BITS-1:0] smul_b;
    logic [PW-1:0]            smul_p;

    logic signed [ZW-1:0]     z_rnd;
    logic signed [16:0]       bearing13;
    logic signed [18:0]       err_raw, err_w1, err_w2;
    logic signed [2*MW-1:0]   ang_sum;
    logic signed [30:0]       ang_raw;
    logic signed [30:0]       max_ang_s;
    logic signed [15:0]       ang_clamped;
    logic [18:0]              err_abs;
    logic [PW-1:0]            lin_sum;
    logic [CW+3:0]            lin_raw;
    logic                     emit_ok;

    assign in_fire = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign age_inc = (r_age == 16'hFFFF) ? r_age : r_age + 16'd1;

    // ---------------- Configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            gtg_pkg::REG_GOAL_TOL: prdata = {1'b0, r_goal_tol};
            gtg_pkg::REG_HEAD_TOL: prdata = {17'd0, r_head_tol};
            gtg_pkg::REG_MAX_LIN:  prdata = {17'd0, r_max_lin};
            gtg_pkg::REG_MAX_ANG:  prdata = {17'd0, r_max_ang};
            gtg_pkg::REG_LIN_GAIN: prdata = {16'd0, r_lin_gain};
            gtg_pkg::REG_ANG_GAIN: prdata = {16'd0, r_ang_gain};
            gtg_pkg::REG_ODOM_TMO: prdata = {16'd0, r_odom_tmo};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_tol <= gtg_pkg::RST_GOAL_TOL;
            r_head_tol <= gtg_pkg::RST_HEAD_TOL;
            r_max_lin  <= gtg_pkg::RST_MAX_LIN;
            r_max_ang  <= gtg_pkg::RST_MAX_ANG;
            r_lin_gain <= gtg_pkg::RST_LIN_GAIN;
            r_ang_gain <= gtg_pkg::RST_ANG_GAIN;
            r_odom_tmo <= gtg_pkg::RST_ODOM_TMO;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                gtg_pkg::REG_GOAL_TOL: r_goal_tol <= pwdata[30:0];
                gtg_pkg::REG_HEAD_TOL: r_head_tol <= pwdata[14:0];
                gtg_pkg::REG_MAX_LIN:  r_max_lin  <= pwdata[14:0];
                gtg_pkg::REG_MAX_ANG:  r_max_ang  <= pwdata[14:0];
                gtg_pkg::REG_LIN_GAIN: r_lin_gain <= pwdata[15:0];
                gtg_pkg::REG_ANG_GAIN: r_ang_gain <= pwdata[15:0];
                gtg_pkg::REG_ODOM_TMO: r_odom_tmo <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- Shared small multiplier ----------------
    // Quaternion products during odometry, gain times heading error on ticks.
    always_comb begin
        unique case (r_state)
            S_Q0:    begin mul_a = MW'(r_qw); mul_b = MW'(r_qz); end
            S_Q1:    begin mul_a = MW'(r_qx); mul_b = MW'(r_qy); end
            S_Q2:    begin mul_a = MW'(r_qy); mul_b = MW'(r_qy); end
            S_Q3:    begin mul_a = MW'(r_qz); mul_b = MW'(r_qz); end
            default: begin
                mul_a = $signed({{(MW-16){1'b0}}, r_ang_gain});
                mul_b = MW'(r_err);
            end
        endcase
    end

    assign prod_cw = CW'(r_prod);

    // ---------------- Shared units ----------------
    gtg_cordic #(.CW(CW), .STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_x     (cord_x_in),
        .i_y     (cord_y_in),
        .o_done  (cord_done),
        .o_x     (cord_x),
        .o_z     (cord_z)
    );

    gtg_smul #(.AW(CW)) u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (smul_start),
        .i_a     (smul_a),
        .i_b     (smul_b),
        .o_done  (smul_done),
        .o_p     (smul_p)
    );

    // The CORDIC starts from the yaw vector after the quaternion products,
    // or from the goal offset when a tick is taken with a goal and fresh odometry.
    always_comb begin
        cord_start = 1'b0;
        cord_x_in  = CW'(r_goal_x) - CW'(r_robot_x);
        cord_y_in  = CW'(r_goal_y) - CW'(r_robot_y);
        if (r_state == S_Q4) begin
            cord_start = 1'b1;
            cord_x_in  = (CW'(1) <<< 28) - ((r_acc2 + prod_cw) <<< 1);
            cord_y_in  = r_acc1 <<< 1;
        end else if (in_fire && i_operation == gtg_pkg::OP_TICK
                     && r_goal_valid && r_odom_valid && age_inc <= r_odom_tmo) begin
            cord_start = 1'b1;
        end
    end

    // The serial multiplier scales the CORDIC magnitude, then the distance.
    always_comb begin
        smul_start = 1'b0;
        smul_a     = cord_x;
        smul_b     = gtg_pkg::CORDIC_GAIN_Q16;
        if (r_state == S_CORD && cord_done) begin
            smul_start = 1'b1;
        end else if (r_state == S_ANG1) begin
            smul_a     = r_dist;
            smul_b     = r_lin_gain;
            smul_start = (err_abs < 19'(r_head_tol));
        end
    end

    // ---------------- Tick arithmetic ----------------
    assign z_rnd     = cord_z + ZW'(4);
    assign bearing13 = 17'(z_rnd >>> 3);
    assign err_raw   = 19'(bearing13) - 19'(r_yaw);
    // The error is wrapped once in each direction, in that order.
    assign err_w1    = (err_raw > gtg_pkg::PI_Q13) ? err_raw - gtg_pkg::TWO_PI_Q13 : err_raw;
    assign err_w2    = (err_w1 < -gtg_pkg::PI_Q13) ? err_w1 + gtg_pkg::TWO_PI_Q13 : err_w1;
    assign err_abs   = (r_err < 0) ? 19'(-r_err) : 19'(r_err);

    assign ang_sum   = r_prod + (2*MW)'(256);
    assign ang_raw   = ang_sum[2*MW-1:9];
    assign max_ang_s = $signed({16'd0, r_max_ang});
    always_comb begin
        priority if (ang_raw > max_ang_s) begin
            ang_clamped = 16'(max_ang_s);
        end else if (ang_raw < -max_ang_s) begin
            ang_clamped = 16'(-max_ang_s);
        end else begin
            ang_clamped = 16'(ang_raw);
        end
    end

    assign lin_sum = smul_p + PW'(2048);
    assign lin_raw = lin_sum[PW-1:12];

    assign emit_ok = !r_out_valid || i_out_ready;

    // ---------------- Sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_goal_x     <= '0;
            r_goal_y     <= '0;
            r_robot_x    <= '0;
            r_robot_y    <= '0;
            r_yaw        <= '0;
            r_goal_valid <= 1'b0;
            r_odom_valid <= 1'b0;
            r_age        <= '0;
        end else begin
            r_prod <= mul_a * mul_b;
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (i_operation)
                            gtg_pkg::OP_GOAL: begin
                                r_goal_x     <= POS_WIDTH'(i_x_coord);
                                r_goal_y     <= POS_WIDTH'(i_y_coord);
                                r_goal_valid <= 1'b1;
                            end
                            gtg_pkg::OP_ODOM: begin
                                r_robot_x    <= POS_WIDTH'(i_x_coord);
                                r_robot_y    <= POS_WIDTH'(i_y_coord);
                                r_qx         <= i_quat_x;
                                r_qy         <= i_quat_y;
                                r_qz         <= i_quat_z;
                                r_qw         <= i_quat_w;
                                r_odom_valid <= 1'b1;
                                r_age        <= '0;
                                r_state      <= S_Q0;
                            end
                            gtg_pkg::OP_TICK: begin
                                r_age <= age_inc;
                                if (r_goal_valid && r_odom_valid) begin
                                    if (age_inc > r_odom_tmo) begin
                                        r_res_lin    <= '0;
                                        r_res_ang    <= '0;
                                        r_res_status <= gtg_pkg::ST_FAILED;
                                        r_goal_valid <= 1'b0;
                                        r_state      <= S_EMIT;
                                    end else begin
                                        r_state <= S_CORD;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // The product of each state is registered and lands in r_prod in the next state.
                S_Q0: r_state <= S_Q1;
                S_Q1: begin
                    r_acc1  <= prod_cw;
                    r_state <= S_Q2;
                end
                S_Q2: begin
                    r_acc1  <= r_acc1 + prod_cw;
                    r_state <= S_Q3;
                end
                S_Q3: begin
                    r_acc2  <= prod_cw;
                    r_state <= S_Q4;
                end
                S_Q4: r_state <= S_YAW;
                S_YAW: begin
                    if (cord_done) begin
                        r_yaw   <= 16'(z_rnd >>> 3);
                        r_state <= S_IDLE;
                    end
                end
                S_CORD: begin
                    if (cord_done) begin
                        r_err   <= err_w2;
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    if (smul_done) begin
                        r_dist  <= CW'((smul_p + PW'(32768)) >> 16);
                        r_state <= S_ARRIVE;
                    end
                end
                S_ARRIVE: begin
                    if (r_dist <= CW'(r_goal_tol)) begin
                        r_res_lin    <= '0;
                        r_res_ang    <= '0;
                        r_res_status <= gtg_pkg::ST_SUCCEEDED;
                        r_goal_valid <= 1'b0;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_ANG0;
                    end
                end
                S_ANG0: r_state <= S_ANG1;
                S_ANG1: begin
                    r_res_ang    <= ang_clamped;
                    r_res_status <= gtg_pkg::ST_DRIVING;
                    r_res_lin    <= '0;
                    r_state      <= smul_start ? S_LIN : S_EMIT;
                end
                S_LIN: begin
                    if (smul_done) begin
                        r_res_lin <= (lin_raw > (CW+4)'(r_max_lin)) ? r_max_lin
                                                                     : 15'(lin_raw);
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- Output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && emit_ok) begin
            r_out_valid  <= 1'b1;
            r_out_lin    <= r_res_lin;
            r_out_ang    <= r_res_ang;
            r_out_status <= r_res_status;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_linear_speed  = r_out_lin;
    assign o_angular_speed = r_out_ang;
    assign o_status        = r_out_status;

endmodule
